/* rtl/core/xzgw_pkg.sv */
// ----------------------------------------------------------------------------
// xzgw_pkg
// Shared types and defaults of the xz-plane gift-wrapping hull block.
// ----------------------------------------------------------------------------
`default_nettype none

package xzgw_pkg;

  // Default store depth and coordinate width
  localparam int unsigned DEF_POINT_CAPACITY = 16;
  localparam int unsigned DEF_COORD_BITS     = 16;

  // Request kind carried on the input tuser
  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } xzgw_op_e;

  // Control sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RES,
    S_FIND,
    S_PUSH,
    S_WRAP_A,
    S_WRAP_B,
    S_EMIT_RD,
    S_EMIT
  } xzgw_state_e;

endpackage

`default_nettype wire

/* rtl/core/xz_gift_wrap_hull.sv */
// ----------------------------------------------------------------------------
// xz_gift_wrap_hull
// Point store in the xz plane with a convex hull recomputed by gift wrapping.
// ----------------------------------------------------------------------------
// Each request either clears the store or adds one point and rebuilds the
// hull. Points live in a one-port-read synchronous memory of {z, x} words;
// the hull vertex list lives in a second small memory. One request is taken
// at a time, only while the sequencer is idle. A clear, a refused add (store
// full) or an add that leaves a single point answers with one result,
// passed through the S_RES state to the output register. An add with n >= 2
// points first scans all n points for the start vertex, then for each hull
// vertex runs an append step, a step that seeds the candidate with point 0,
// and for each further point one memory read and multiply step plus one
// compare step, then a read step and an emit step per emitted vertex. The
// scan is serialised by the single point memory read port shared by the
// start search and the wrap scan. Results leave through an output register,
// so a stalled consumer only holds emission. Result indices follow hull
// order from the lowest-x (then lowest-z) point; the reject flag travels on
// m_axis_tuser and the last vertex is marked by m_axis_tlast.
// ----------------------------------------------------------------------------
`default_nettype none

module xz_gift_wrap_hull #(
  parameter int unsigned POINT_CAPACITY = xzgw_pkg::DEF_POINT_CAPACITY,
  parameter int unsigned COORD_BITS     = xzgw_pkg::DEF_COORD_BITS,
  localparam int unsigned IDX_W  = $clog2(POINT_CAPACITY),
  localparam int unsigned CNT_W  = $clog2(POINT_CAPACITY + 1),
  localparam int unsigned IN_W   = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W  = ((IDX_W + CNT_W + 7) / 8) * 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Request channel
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,   // point_x, point_z
  input  wire logic             s_axis_tuser,   // opcode
  // Result channel
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,   // vertex_index, vertex_total
  output logic                  m_axis_tlast,   // run_end
  output logic                  m_axis_tuser    // point_dropped
);

  import xzgw_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = CB + 1;      // coordinate difference
  localparam int unsigned PW = 2 * DW;      // exact cross-product term

  // --------------------------------------------------------------------------
  // Control and datapath registers
  // --------------------------------------------------------------------------
  xzgw_state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;       // stored points
  logic [CNT_W-1:0] hlen_q, hlen_d;         // hull vertices so far
  logic [IDX_W-1:0] cnt_q, cnt_d;           // scan / emit position
  logic [IDX_W-1:0] start_q, start_d;       // first hull vertex
  // current vertex (start search winner, then wrap position)
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic [CB-1:0]    best_x_q, best_x_d, best_z_q, best_z_d;
  // running wrap candidate
  logic [IDX_W-1:0] nxt_idx_q, nxt_idx_d;
  logic [CB-1:0]    nxt_x_q, nxt_x_d, nxt_z_q, nxt_z_d;
  // registered cross-product terms
  logic signed [PW-1:0] prod_a_q, prod_a_d, prod_b_q, prod_b_d;
  // pending single result
  logic [CNT_W-1:0] res_tot_q, res_tot_d;
  logic             res_drop_q, res_drop_d;
  // output register
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  logic [CNT_W-1:0] out_tot_q, out_tot_d;
  logic             out_last_q, out_last_d;
  logic             out_drop_q, out_drop_d;

  // --------------------------------------------------------------------------
  // Memories: point store {z, x} and hull vertex list
  // --------------------------------------------------------------------------
  logic [2*CB-1:0]  pt_mem [POINT_CAPACITY];
  logic             pt_we, pt_re;
  logic [IDX_W-1:0] pt_waddr, pt_raddr;
  logic [2*CB-1:0]  pt_wdata, pt_rdata_q;

  logic [IDX_W-1:0] hl_mem [POINT_CAPACITY];
  logic             hl_we;
  logic [IDX_W-1:0] hl_waddr, hl_wdata, hl_rdata_q;

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    if (pt_re) begin
      pt_rdata_q <= pt_mem[pt_raddr];
    end
  end

  // Hull list is read every cycle at the emit position
  always_ff @(posedge clk_i) begin
    if (hl_we) begin
      hl_mem[hl_waddr] <= hl_wdata;
    end
    hl_rdata_q <= hl_mem[cnt_q];
  end

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic [CB-1:0] rd_x, rd_z, in_x, in_z;
  logic          accept, out_free, last_pt, lower, take;
  logic signed [DW-1:0] u1, v1, u2, v2;

  assign rd_x = pt_rdata_q[CB-1:0];
  assign rd_z = pt_rdata_q[2*CB-1:CB];
  assign in_x = s_axis_tdata[CB-1:0];
  assign in_z = s_axis_tdata[2*CB-1:CB];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Scan position holds the last stored point
  assign last_pt = (CNT_W'(cnt_q) == (count_q - CNT_W'(1)));

  // Lowest x, then lowest z; strict, so the first index wins ties
  assign lower = ($signed(rd_x) < $signed(best_x_q)) ||
                 ((rd_x == best_x_q) && ($signed(rd_z) < $signed(best_z_q)));

  // Differences from the current vertex, sign-extended by one bit
  assign u1 = $signed({nxt_x_q[CB-1], nxt_x_q}) - $signed({best_x_q[CB-1], best_x_q});
  assign v1 = $signed({nxt_z_q[CB-1], nxt_z_q}) - $signed({best_z_q[CB-1], best_z_q});
  assign u2 = $signed({rd_x[CB-1], rd_x}) - $signed({best_x_q[CB-1], best_x_q});
  assign v2 = $signed({rd_z[CB-1], rd_z}) - $signed({best_z_q[CB-1], best_z_q});

  // Replace the candidate when it is the current vertex, or when the point
  // under test lies strictly past it (negative cross product)
  assign take = (best_idx_q == nxt_idx_q) || (prod_a_q < prod_b_q);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    hlen_d      = hlen_q;
    cnt_d       = cnt_q;
    start_d     = start_q;
    best_idx_d  = best_idx_q;
    best_x_d    = best_x_q;
    best_z_d    = best_z_q;
    nxt_idx_d   = nxt_idx_q;
    nxt_x_d     = nxt_x_q;
    nxt_z_d     = nxt_z_q;
    prod_a_d    = prod_a_q;
    prod_b_d    = prod_b_q;
    res_tot_d   = res_tot_q;
    res_drop_d  = res_drop_q;
    out_idx_d   = out_idx_q;
    out_tot_d   = out_tot_q;
    out_last_d  = out_last_q;
    out_drop_d  = out_drop_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    pt_we    = 1'b0;
    pt_waddr = count_q[IDX_W-1:0];
    pt_wdata = {in_z, in_x};
    pt_re    = 1'b0;
    pt_raddr = '0;
    hl_we    = 1'b0;
    hl_waddr = hlen_q[IDX_W-1:0];
    hl_wdata = best_idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (xzgw_op_e'(s_axis_tuser))
            OP_CLEAR: begin
              count_d    = '0;
              hlen_d     = '0;
              res_tot_d  = '0;
              res_drop_d = 1'b0;
              state_d    = S_RES;
            end
            OP_ADD: begin
              if (count_q == CNT_W'(POINT_CAPACITY)) begin
                // Store full: refuse, report the unchanged hull length
                res_tot_d  = hlen_q;
                res_drop_d = 1'b1;
                state_d    = S_RES;
              end else begin
                pt_we   = 1'b1;
                count_d = count_q + CNT_W'(1);
                if (count_q == '0) begin
                  hlen_d     = '0;
                  res_tot_d  = '0;
                  res_drop_d = 1'b0;
                  state_d    = S_RES;
                end else begin
                  // Start the lowest-left search at point 0
                  pt_re    = 1'b1;
                  pt_raddr = '0;
                  cnt_d    = '0;
                  state_d  = S_FIND;
                end
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_RES: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = '0;
          out_tot_d   = res_tot_q;
          out_last_d  = 1'b1;
          out_drop_d  = res_drop_q;
          state_d     = S_IDLE;
        end
      end

      S_FIND: begin
        if ((cnt_q == '0) || lower) begin
          best_idx_d = cnt_q;
          best_x_d   = rd_x;
          best_z_d   = rd_z;
        end
        if (last_pt) begin
          hlen_d  = '0;
          state_d = S_PUSH;
        end else begin
          pt_re    = 1'b1;
          pt_raddr = cnt_q + IDX_W'(1);
          cnt_d    = cnt_q + IDX_W'(1);
        end
      end

      S_PUSH: begin
        // Append the current vertex and rescan all points from index 0
        hl_we  = 1'b1;
        hlen_d = hlen_q + CNT_W'(1);
        if (hlen_q == '0) begin
          start_d = best_idx_q;
        end
        pt_re    = 1'b1;
        pt_raddr = '0;
        cnt_d    = '0;
        state_d  = S_WRAP_A;
      end

      S_WRAP_A: begin
        if (cnt_q == '0) begin
          // Point 0 seeds the candidate
          nxt_idx_d = '0;
          nxt_x_d   = rd_x;
          nxt_z_d   = rd_z;
          pt_re     = 1'b1;
          pt_raddr  = IDX_W'(1);
          cnt_d     = IDX_W'(1);
        end else begin
          prod_a_d = PW'(u1) * PW'(v2);
          prod_b_d = PW'(v1) * PW'(u2);
          state_d  = S_WRAP_B;
        end
      end

      S_WRAP_B: begin
        if (take) begin
          nxt_idx_d = cnt_q;
          nxt_x_d   = rd_x;
          nxt_z_d   = rd_z;
        end
        if (last_pt) begin
          // Advance to the chosen vertex unless back at the start or full
          if (((take ? cnt_q : nxt_idx_q) != start_q) &&
              (hlen_q < CNT_W'(POINT_CAPACITY))) begin
            best_idx_d = take ? cnt_q : nxt_idx_q;
            best_x_d   = take ? rd_x  : nxt_x_q;
            best_z_d   = take ? rd_z  : nxt_z_q;
            state_d    = S_PUSH;
          end else begin
            cnt_d   = '0;
            state_d = S_EMIT_RD;
          end
        end else begin
          pt_re    = 1'b1;
          pt_raddr = cnt_q + IDX_W'(1);
          cnt_d    = cnt_q + IDX_W'(1);
          state_d  = S_WRAP_A;
        end
      end

      S_EMIT_RD: begin
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = hl_rdata_q;
          out_tot_d   = hlen_q;
          out_last_d  = (CNT_W'(cnt_q) == (hlen_q - CNT_W'(1)));
          out_drop_d  = 1'b0;
          if (CNT_W'(cnt_q) == (hlen_q - CNT_W'(1))) begin
            state_d = S_IDLE;
          end else begin
            cnt_d   = cnt_q + IDX_W'(1);
            state_d = S_EMIT_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      hlen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      hlen_q      <= hlen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    start_q    <= start_d;
    best_idx_q <= best_idx_d;
    best_x_q   <= best_x_d;
    best_z_q   <= best_z_d;
    nxt_idx_q  <= nxt_idx_d;
    nxt_x_q    <= nxt_x_d;
    nxt_z_q    <= nxt_z_d;
    prod_a_q   <= prod_a_d;
    prod_b_q   <= prod_b_d;
    res_tot_q  <= res_tot_d;
    res_drop_q <= res_drop_d;
    out_idx_q  <= out_idx_d;
    out_tot_q  <= out_tot_d;
    out_last_q <= out_last_d;
    out_drop_q <= out_drop_d;
  end

  // --------------------------------------------------------------------------
  // Result port
  // --------------------------------------------------------------------------
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_tot_q, out_idx_q});
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_drop_q;

endmodule

`default_nettype wire
